>>> rtl/p2a_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2a_pkg
// Shared types and constants for the pixel to glyph and hue block.
// ----------------------------------------------------------------------------
package p2a_pkg;

  localparam int PIX_W       = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] cmax;
    logic [PIX_W-1:0] luma;
    logic             color_en;
  } item_t;

endpackage

>>> rtl/p2a_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2a_front
// Accepts pixels, computes luma and the largest channel, and tags each beat
// with the current colour enable before it enters the queue.
// ----------------------------------------------------------------------------
module p2a_front import p2a_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  output logic        push_valid,
  input  logic        push_ready,
  output item_t       push_item
);

  localparam logic [23:0] LUMA_WR = 24'd19595;
  localparam logic [23:0] LUMA_WG = 24'd38470;
  localparam logic [23:0] LUMA_WB = 24'd7471;

  logic             color_en_r;
  logic             color_en_nxt;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;
  logic [PIX_W-1:0] max_rg;
  logic [23:0]      luma_sum;

  assign cfg_ready = 1'b1;

  always_comb begin
    color_en_nxt = color_en_r;
    if (cfg_valid && cfg_ready) begin
      color_en_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_en_r <= 1'b1;
    end else begin
      color_en_r <= color_en_nxt;
    end
  end

  assign red   = in_tdata[7:0];
  assign green = in_tdata[15:8];
  assign blue  = in_tdata[23:16];

  assign luma_sum = LUMA_WR * 24'(red) + LUMA_WG * 24'(green) + LUMA_WB * 24'(blue);
  assign max_rg   = (green > red) ? green : red;

  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;

  always_comb begin
    push_item.red      = red;
    push_item.green    = green;
    push_item.blue     = blue;
    push_item.cmax     = (blue > max_rg) ? blue : max_rg;
    push_item.luma     = luma_sum[23:16];
    push_item.color_en = color_en_r;
  end

endmodule

>>> rtl/p2a_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2a_queue
// Short register queue that decouples the front from the divider pipeline.
// ----------------------------------------------------------------------------
module p2a_queue import p2a_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> rtl/p2a_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2a_back
// Glyph lookup and a pipelined restoring divider for the full-value hue.
// ----------------------------------------------------------------------------
module p2a_back import p2a_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  item_t       pop_item,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  output logic        out_tuser
);

  localparam int DIV_STEPS = PIX_W;
  localparam int NUM_CH    = 3;
  localparam logic [3:0] LEVEL_MAX = 4'd9;
  localparam logic [9:0][6:0] GLYPH_RAMP = {
    7'd64, 7'd56, 7'd79, 7'd111, 7'd99, 7'd43, 7'd59, 7'd58, 7'd46, 7'd32
  };

  typedef struct packed {
    logic [PIX_W-1:0]             luma;
    logic [3:0]                   level;
    logic [6:0]                   code;
    logic                         color_en;
    logic [PIX_W-1:0]             divisor;
    logic [NUM_CH-1:0][PIX_W-1:0] rem;
    logic [NUM_CH-1:0][PIX_W-1:0] low;
    logic [NUM_CH-1:0][PIX_W-1:0] quot;
  } stage_t;

  stage_t st_r  [DIV_STEPS+1];
  stage_t st_nxt[DIV_STEPS+1];
  logic   vld_r [DIV_STEPS+1];
  logic   advance;

  logic [11:0]                  lvl_x;
  logic [11:0]                  lvl_q;
  logic [3:0]                   lvl;
  logic [NUM_CH-1:0][PIX_W-1:0] chan;
  logic [NUM_CH-1:0][15:0]      numer;

  assign advance   = !vld_r[DIV_STEPS] || out_tready;
  assign pop_ready = advance;

  always_comb begin
    lvl_x = {1'b0, pop_item.luma, 3'b0} + {3'b0, pop_item.luma, 1'b0};
    lvl_q = lvl_x + (lvl_x >> 8) + 12'd1;
    lvl   = (lvl_q[11:8] > LEVEL_MAX) ? LEVEL_MAX : lvl_q[11:8];
    chan  = {pop_item.blue, pop_item.green, pop_item.red};
    st_nxt[0].luma     = pop_item.luma;
    st_nxt[0].level    = lvl;
    st_nxt[0].code     = GLYPH_RAMP[lvl];
    st_nxt[0].color_en = pop_item.color_en;
    st_nxt[0].divisor  = pop_item.cmax;
    st_nxt[0].quot     = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      numer[c]         = {chan[c], 8'b0} - {8'b0, chan[c]};
      st_nxt[0].rem[c] = numer[c][15:8];
      st_nxt[0].low[c] = numer[c][7:0];
    end
  end

  // A black pixel has a zero divisor; every step then sets its quotient bit,
  // which yields 255 on all three channels.
  for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_div
    logic [NUM_CH-1:0][PIX_W:0] trial;
    always_comb begin
      st_nxt[s] = st_r[s-1];
      for (int c = 0; c < NUM_CH; c++) begin
        trial[c] = {st_r[s-1].rem[c], st_r[s-1].low[c][PIX_W-1]};
        st_nxt[s].low[c] = {st_r[s-1].low[c][PIX_W-2:0], 1'b0};
        if (trial[c] >= {1'b0, st_r[s-1].divisor}) begin
          st_nxt[s].rem[c]  = PIX_W'(trial[c] - {1'b0, st_r[s-1].divisor});
          st_nxt[s].quot[c] = {st_r[s-1].quot[c][PIX_W-2:0], 1'b1};
        end else begin
          st_nxt[s].rem[c]  = trial[c][PIX_W-1:0];
          st_nxt[s].quot[c] = {st_r[s-1].quot[c][PIX_W-2:0], 1'b0};
        end
      end
    end
  end

  for (genvar s = 0; s <= DIV_STEPS; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (advance) begin
        vld_r[s] <= (s == 0) ? pop_valid : vld_r[(s == 0) ? 0 : s-1];
      end
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  logic [PIX_W-1:0] hue_red;
  logic [PIX_W-1:0] hue_green;
  logic [PIX_W-1:0] hue_blue;

  assign hue_red    = st_r[DIV_STEPS].color_en ? st_r[DIV_STEPS].quot[0] : '0;
  assign hue_green  = st_r[DIV_STEPS].color_en ? st_r[DIV_STEPS].quot[1] : '0;
  assign hue_blue   = st_r[DIV_STEPS].color_en ? st_r[DIV_STEPS].quot[2] : '0;
  assign out_tvalid = vld_r[DIV_STEPS];
  assign out_tuser  = st_r[DIV_STEPS].color_en;
  assign out_tdata  = {5'b0, hue_blue, hue_green, hue_red, st_r[DIV_STEPS].code,
                       st_r[DIV_STEPS].level, st_r[DIV_STEPS].luma};

`ifndef SYNTHESIS
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[11:8] <= LEVEL_MAX))
    else $error("glyph level out of range");

  a_hue_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[42:19] == '0))
    else $error("hue fields not cleared while colour is off");

  a_pipe_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && vld_r[0]) |=> vld_r[1])
    else $error("beat lost between pipeline stages");

  a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |=> vld_r[0])
    else $error("popped beat not captured");
`endif

endmodule

>>> rtl/pixel_to_ascii_glyph_and_hue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_to_ascii_glyph_and_hue
// Turns one RGB pixel per beat into a character cell: luma, ramp glyph and
// the pixel's hue at full value.
// ----------------------------------------------------------------------------
// Pixels enter on the in_ stream and results leave on the out_ stream, one
// result beat per pixel, in order. The cfg_ channel writes the color enable;
// it is always ready and should only be written while the block is empty.
// The block sustains one pixel per clock while out_tready stays high. The beat
// passes the input queue, the glyph stage and eight restoring-division steps,
// the last of which is the output register. When out_tready is low with a
// result waiting, the divider pipeline holds; the two-entry queue in front of
// it keeps taking pixels until it fills, then in_tready drops. Reset empties
// the queue and pipeline and sets the color enable to one. With color disabled
// the hue fields are zero and out_tuser is low.
// ----------------------------------------------------------------------------
module pixel_to_ascii_glyph_and_hue import p2a_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel_red, pixel_green, pixel_blue
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // luma, glyph_level, glyph_code, hue_red, hue_green, hue_blue
  output logic        out_tuser,  // hue_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  p2a_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  p2a_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  p2a_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
